// ----- rtl/core/cfd_pkg.sv -----
// shared types, codes and constants of the checksummed frame deframer
`default_nettype none

package cfd_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned RESULT_CAP = 27;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned TUSER_W    = 3;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_MAXL = 2'd2;

  localparam logic [DATA_W-1:0] HEAD_RST = 8'h40;
  localparam logic [DATA_W-1:0] TAIL_RST = 8'h0D;
  localparam logic [LEN_W-1:0]  MAXL_RST = 5'd27;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_TAIL = 2'd2,
    ST_BAD_SUM  = 2'd3
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] head_byte;
    logic [DATA_W-1:0] tail_byte;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfd_cfg.sv -----
// apb configuration registers of the checksummed frame deframer
`default_nettype none

module cfd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfd_pkg::APB_AW-1:0] paddr,
  input  logic [cfd_pkg::APB_DW-1:0] pwdata,
  output logic [cfd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output cfd_pkg::cfg_t             cfg_o
);
  import cfd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HEAD: cfg_d.head_byte  = pwdata[DATA_W-1:0];
        REG_TAIL: cfg_d.tail_byte  = pwdata[DATA_W-1:0];
        REG_MAXL: cfg_d.max_length = pwdata[LEN_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte  <= HEAD_RST;
      cfg_q.tail_byte  <= TAIL_RST;
      cfg_q.max_length <= MAXL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_HEAD: prdata = APB_DW'(cfg_q.head_byte);
      REG_TAIL: prdata = APB_DW'(cfg_q.tail_byte);
      REG_MAXL: prdata = APB_DW'(cfg_q.max_length);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/checksummed_frame_deframer.sv -----
// top level: frame parser, frame store memory and burst emitter
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata = rx_byte
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata = out_byte, tuser = status/is_command,
//                                              tlast = last
//   apb       in   psel & penable (pready = 1)  head_byte, tail_byte, max_length
//
// one received byte per cycle while the output register is free or being drained
// a good frame's tail byte starts a burst of n results (n = length byte, up to 27);
// each result is a frame store read, then an output register load that waits while
// the output is stalled, and no byte is taken during the burst
// error results are loaded straight into the output register on the failing byte
// async reset returns to hunting and empties the output register; the frame store
// is never cleared, only bytes of the current frame are read back
`default_nettype none

module checksummed_frame_deframer #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
  output logic [cfd_pkg::TUSER_W-1:0] m_axis_tuser,   // [0] is_command, [2:1] status
  output logic                        m_axis_tlast,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfd_pkg::APB_AW-1:0]  paddr,
  input  logic [cfd_pkg::APB_DW-1:0]  pwdata,
  output logic [cfd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import cfd_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  // longest frame the store and the result limit can hold
  localparam int unsigned CAP_INT = (STORE_DEPTH - 5 < RESULT_CAP) ? STORE_DEPTH - 5
                                                                   : RESULT_CAP;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

  // parser phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;
  localparam logic [2:0] PH_RD   = 3'd5;  // burst: read frame store
  localparam logic [2:0] PH_EMIT = 3'd6;  // burst: load output register

  cfg_t cfg;

  cfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // parser state
  logic [2:0]        phase_q, phase_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] sum_q, sum_d;
  logic [DATA_W-1:0] chk_q, chk_d;

  // output register
  logic              ovalid_q, ovalid_d;
  logic [DATA_W-1:0] obyte_q, obyte_d;
  logic              ocmd_q, ocmd_d;
  logic              olast_q, olast_d;
  status_e           ostat_q, ostat_d;

  // frame store
  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;
  logic              mem_re;

  logic              bursting;
  logic              out_free;
  logic              in_fire;
  logic [LEN_W-1:0]  limit;
  logic [DATA_W-1:0] b;

  assign bursting      = (phase_q == PH_RD) || (phase_q == PH_EMIT);
  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = !bursting && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign limit         = (cfg.max_length < LEN_CAP) ? cfg.max_length : LEN_CAP;

  assign mem_we = in_fire && (phase_q == PH_DATA);
  assign mem_re = (phase_q == PH_RD);

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    chk_d    = chk_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    obyte_d  = obyte_q;
    ocmd_d   = ocmd_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;

    if (in_fire) begin
      case (phase_q)
        PH_LEN: begin
          if (b == '0 || b > DATA_W'(limit)) begin
            // bad length, single error result
            ovalid_d = 1'b1;
            obyte_d  = '0;
            ocmd_d   = 1'b0;
            olast_d  = 1'b1;
            ostat_d  = ST_BAD_LEN;
            phase_d  = PH_HUNT;
          end else begin
            len_d   = b[LEN_W-1:0];
            cnt_d   = '0;
            sum_d   = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d = sum_q + b;
          cnt_d = cnt_q + LEN_W'(1);
          if (cnt_d >= len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          chk_d   = b;
          phase_d = PH_TAIL;
        end
        PH_TAIL: begin
          if (b != cfg.tail_byte || chk_q != sum_q) begin
            // bad tail wins over bad checksum
            ovalid_d = 1'b1;
            obyte_d  = '0;
            ocmd_d   = 1'b0;
            olast_d  = 1'b1;
            ostat_d  = (b != cfg.tail_byte) ? ST_BAD_TAIL : ST_BAD_SUM;
            phase_d  = PH_HUNT;
          end else begin
            idx_d   = '0;
            phase_d = PH_RD;
          end
        end
        default: begin
          // hunting, unused codes fall back here too
          phase_d = (b == cfg.head_byte) ? PH_LEN : PH_HUNT;
        end
      endcase
    end else begin
      case (phase_q)
        PH_RD: begin
          phase_d = PH_EMIT;
        end
        PH_EMIT: begin
          if (out_free) begin
            ovalid_d = 1'b1;
            obyte_d  = rdata_q;
            ocmd_d   = (idx_q == '0);
            olast_d  = (idx_q + LEN_W'(1) == len_q);
            ostat_d  = ST_GOOD;
            idx_d    = idx_q + LEN_W'(1);
            phase_d  = olast_d ? PH_HUNT : PH_RD;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      chk_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      chk_q    <= chk_d;
      ovalid_q <= ovalid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    ocmd_q  <= ocmd_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ADDR_W'(cnt_q)] <= b;
    end
    if (mem_re) begin
      rdata_q <= mem[ADDR_W'(idx_q)];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = {ostat_q, ocmd_q};
  assign m_axis_tlast  = olast_q;

`ifndef SYNTHESIS
  // no byte is taken while a burst is being emitted
  a_no_input_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bursting |-> !s_axis_tready)
    else $error("input accepted during burst");

  // error results carry zero data and close the transfer group
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q != ST_GOOD) |-> (olast_q && obyte_q == '0 && !ocmd_q))
    else $error("malformed error result");

  // a frame being stored always has a legal length
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (len_q != '0 && len_q <= LEN_CAP && cnt_q < len_q))
    else $error("frame length out of range");

  // burst reads stay inside the frame
  a_burst_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bursting |-> (idx_q < len_q))
    else $error("burst index past frame end");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for the checksummed frame deframer: directed and random frames checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  localparam int unsigned STORE_DEPTH   = 32;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned IDLE_LIMIT    = 3000;          // cycles with no transfer anywhere
  localparam int unsigned ITEM_TARGET   = 280;
  localparam int unsigned N_SETTINGS    = 5;
  localparam int unsigned SETTLE_CYCLES = 2 * RESULT_CAP + 8;  // longest burst plus margin

  // parser phases of the predictor
  typedef enum logic [2:0] {
    P_HUNT,
    P_LEN,
    P_DATA,
    P_SUM,
    P_TAIL
  } parse_phase_e;

  // shapes of generated byte sequences
  typedef enum int {
    FR_GOOD,
    FR_BAD_LEN,
    FR_BAD_TAIL,
    FR_BAD_SUM,
    FR_NOISE
  } frame_kind_e;

  // one output beat as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       is_cmd;
    logic       last;
    status_e    status;
  } out_beat_t;

  // clock, reset and block ports, all driven from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // [7:0] out_byte
  logic [TUSER_W-1:0]   m_axis_tuser;         // [0] is_command, [2:1] status
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [APB_AW-1:0]    paddr         = '0;
  logic [APB_DW-1:0]    pwdata        = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // predictor state: its own copy of the registers and of the parser
  cfg_t                 model_cfg;
  parse_phase_e         model_phase;
  logic [4:0]           model_len;
  logic [4:0]           model_count;
  logic [7:0]           model_sum;
  logic [7:0]           model_rx_sum;
  logic [7:0]           model_store [STORE_DEPTH];
  out_beat_t            expected_q [$];

  // bookkeeping
  int unsigned          err_count     = 0;
  int unsigned          items_sent    = 0;
  int unsigned          frames_sent   = 0;
  int unsigned          results_seen  = 0;
  int unsigned          idle_cycles   = 0;
  int unsigned          tx_gap_max    = 8;
  int unsigned          rx_gap_max    = 8;
  int unsigned          rx_hold       = 0;

  checksummed_frame_deframer #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // accepted length: max_length, clipped by the store depth and the burst cap
  function automatic int unsigned length_bound();
    int unsigned lim;
    int unsigned cap;
    lim = 32'(model_cfg.max_length);
    cap = (STORE_DEPTH > 5) ? STORE_DEPTH - 5 : 0;
    if (cap > RESULT_CAP) cap = RESULT_CAP;
    return (lim < cap) ? lim : cap;
  endfunction

  // an error is a single zero beat carrying the status, and parsing restarts
  function automatic void push_error(input status_e st);
    out_beat_t e;
    e.data   = '0;
    e.is_cmd = 1'b0;
    e.last   = 1'b1;
    e.status = st;
    expected_q.push_back(e);
    model_phase = P_HUNT;
  endfunction

  // advance the parser by one accepted byte and queue the beats it causes
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned n;
    out_beat_t   e;
    case (model_phase)
      P_LEN: begin
        if (b == 8'd0 || 32'(b) > length_bound()) begin
          push_error(ST_BAD_LEN);
        end else begin
          model_len   = b[4:0];
          model_count = '0;
          model_sum   = '0;
          model_phase = P_DATA;
        end
      end
      P_DATA: begin
        if (model_count < STORE_DEPTH) model_store[model_count] = b;
        model_sum   = model_sum + b;
        model_count = model_count + 5'd1;
        if (model_count >= model_len) model_phase = P_SUM;
      end
      P_SUM: begin
        model_rx_sum = b;
        model_phase  = P_TAIL;
      end
      P_TAIL: begin
        // tail is judged before the checksum
        if (b != model_cfg.tail_byte) begin
          push_error(ST_BAD_TAIL);
        end else if (model_rx_sum != model_sum) begin
          push_error(ST_BAD_SUM);
        end else begin
          n = 32'(model_len);
          if (n > RESULT_CAP) n = RESULT_CAP;
          if (n > STORE_DEPTH) n = STORE_DEPTH;
          for (int unsigned i = 0; i < n; i++) begin
            e.data   = model_store[i];
            e.is_cmd = (i == 0);
            e.last   = (i + 1 == n);
            e.status = ST_GOOD;
            expected_q.push_back(e);
          end
          model_phase = P_HUNT;
        end
      end
      default: begin
        // hunting: anything but the head byte is dropped silently
        model_phase = (b == model_cfg.head_byte) ? P_LEN : P_HUNT;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string what, input int unsigned got, input int unsigned want);
    if (err_count < 100)
      $display("ERROR at %0t ns: %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // every output transfer is held against the oldest queued beat
  always @(posedge clk_i) begin : out_check
    out_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      rx_hold = $urandom_range(0, rx_gap_max);
      if (expected_q.size() == 0) begin
        flag_error("output transfer with nothing expected, tdata", 32'(m_axis_tdata), 0);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== e.data)
          flag_error("out_byte", 32'(m_axis_tdata), 32'(e.data));
        if (m_axis_tuser[0] !== e.is_cmd)
          flag_error("is_command", 32'(m_axis_tuser[0]), 32'(e.is_cmd));
        if (m_axis_tuser[2:1] !== e.status)
          flag_error("status", 32'(m_axis_tuser[2:1]), 32'(e.status));
        if (m_axis_tlast !== e.last)
          flag_error("last", 32'(m_axis_tlast), 32'(e.last));
      end
    end
  end

  // receiver: after each transfer, hold tready low for the drawn number of cycles
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // a hang shows up as a long run of cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one byte over the input stream; tvalid stays up so gap-free bytes go back to back
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    deframe_byte(b);
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
    frames_sent++;
  endtask

  // stop sending and let every queued beat come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle; pready is waited for even though it stays high
  task automatic apb_transfer(input logic [1:0] idx, input logic wr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_check(input logic [1:0] idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_transfer(idx, 1'b0, '0, rd);
    if (rd !== want) flag_error($sformatf("register %0d readback", idx), rd, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_transfer(idx, 1'b1, value, rd);
    case (idx)
      REG_HEAD: model_cfg.head_byte  = value[7:0];
      REG_TAIL: model_cfg.tail_byte  = value[7:0];
      REG_MAXL: model_cfg.max_length = value[4:0];
      default: ;
    endcase
    read_check(idx, value);
  endtask

  // registers change only once the block has gone quiet
  task automatic set_framing(input logic [7:0] head, input logic [7:0] tail, input logic [4:0] maxl);
    wait_drained();
    settle();
    write_reg(REG_HEAD, APB_DW'(head));
    write_reg(REG_TAIL, APB_DW'(tail));
    write_reg(REG_MAXL, APB_DW'(maxl));
  endtask

  // one generated sequence: a frame of the given kind, or len noise bytes
  task automatic send_frame(input frame_kind_e kind, input int unsigned len);
    logic [7:0]   seq [$];
    logic [7:0]   d;
    logic [7:0]   sum;
    logic [7:0]   chk;
    logic [7:0]   tl;
    int unsigned  bound;
    bound = length_bound();
    sum   = '0;
    case (kind)
      FR_NOISE: begin
        // noise avoids the head byte so the next frame stays aligned
        repeat (len) begin
          d = 8'($urandom);
          if (d == model_cfg.head_byte) d = d + 8'd1;
          seq.push_back(d);
        end
      end
      FR_BAD_LEN: begin
        seq.push_back(model_cfg.head_byte);
        if ($urandom_range(0, 1) == 0 || bound >= 255)
          seq.push_back(8'd0);
        else
          seq.push_back(8'($urandom_range(bound + 1, 255)));
      end
      default: begin
        seq.push_back(model_cfg.head_byte);
        seq.push_back(8'(len));
        repeat (len) begin
          d   = 8'($urandom);
          sum = sum + d;
          seq.push_back(d);
        end
        chk = sum;
        tl  = model_cfg.tail_byte;
        if (kind == FR_BAD_SUM)
          chk = sum ^ 8'($urandom_range(1, 255));
        if (kind == FR_BAD_TAIL) begin
          tl = tl ^ 8'($urandom_range(1, 255));
          // half the time the checksum is wrong too, the tail must still win
          if ($urandom_range(0, 1) == 1) chk = sum ^ 8'($urandom_range(1, 255));
        end
        seq.push_back(chk);
        seq.push_back(tl);
      end
    endcase
    send_seq(seq);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    read_check(REG_HEAD, APB_DW'(HEAD_RST));
    read_check(REG_TAIL, APB_DW'(TAIL_RST));
    read_check(REG_MAXL, APB_DW'(MAXL_RST));
  endtask

  // hand-built sequences at the reset register values
  task automatic test_directed_frames();
    tx_gap_max = 8;
    rx_gap_max = 8;
    // stray byte while hunting is dropped
    send_seq('{8'hFF});
    // one-byte frame: command only, marked last
    send_seq('{HEAD_RST, 8'd1, 8'hA5, 8'hA5, TAIL_RST});
    // data extremes
    send_seq('{HEAD_RST, 8'd2, 8'h00, 8'hFF, 8'hFF, TAIL_RST});
    // length byte zero
    send_seq('{HEAD_RST, 8'd0});
    // length one above the limit
    send_seq('{HEAD_RST, 8'd28});
    // wrong tail with a good checksum
    send_seq('{HEAD_RST, 8'd1, 8'h3C, 8'h3C, TAIL_RST ^ 8'h01});
    // good tail, wrong checksum
    send_seq('{HEAD_RST, 8'd1, 8'h11, 8'h12, TAIL_RST});
  endtask

  // mostly well-formed frames with random content, plus broken frames and noise,
  // under several register settings and idling mixes
  task automatic test_random_frames();
    int unsigned  target;
    int unsigned  r;
    int unsigned  bound;
    int unsigned  len;
    bit           paused;
    frame_kind_e  kind;
    for (int unsigned s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: begin
          set_framing(HEAD_RST, TAIL_RST, MAXL_RST);
          tx_gap_max = 8;
          rx_gap_max = 8;
        end
        1: begin
          // smallest limit, no idling at all
          set_framing(8'h00, 8'hFF, 5'd1);
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        2: begin
          set_framing(8'hFF, 8'h00, 5'd27);
          tx_gap_max = 8;
          rx_gap_max = 0;
        end
        3: begin
          set_framing(8'($urandom), 8'($urandom), 5'($urandom_range(1, 27)));
          tx_gap_max = 0;
          rx_gap_max = 8;
        end
        default: begin
          set_framing(8'($urandom), 8'($urandom), 5'($urandom_range(1, 27)));
          tx_gap_max = 8;
          rx_gap_max = 8;
        end
      endcase
      target = items_sent + ITEM_TARGET / N_SETTINGS;
      paused = 1'b0;
      // a full-length frame once, at the widest limit
      if (s == 2) send_frame(FR_GOOD, length_bound());
      while (items_sent < target) begin
        // in the last setting the sender waits once for the output to empty mid-stream
        if (s == N_SETTINGS - 1 && !paused && items_sent + 25 >= target) begin
          wait_drained();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 64)      kind = FR_GOOD;
        else if (r < 72) kind = FR_BAD_LEN;
        else if (r < 80) kind = FR_BAD_TAIL;
        else if (r < 88) kind = FR_BAD_SUM;
        else             kind = FR_NOISE;
        bound = length_bound();
        // short frames mostly, the limit itself now and then
        if ($urandom_range(0, 7) == 0)
          len = bound;
        else
          len = $urandom_range(1, (bound < 6) ? bound : 6);
        if (kind == FR_NOISE) len = $urandom_range(1, 3);
        send_frame(kind, len);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    model_cfg    = '{head_byte: HEAD_RST, tail_byte: TAIL_RST, max_length: MAXL_RST};
    model_phase  = P_HUNT;
    model_len    = '0;
    model_count  = '0;
    model_sum    = '0;
    model_rx_sum = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed_frames();
    test_random_frames();

    wait_drained();
    settle();

    $display("summary: %0d bytes in %0d sequences sent, %0d output beats checked",
             items_sent, frames_sent, results_seen);
    $display("summary: %0d register settings incl. extremes, directed error and one-byte cases",
             N_SETTINGS + 1);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cfd_pkg.sv
rtl/core/cfd_cfg.sv
rtl/core/checksummed_frame_deframer.sv
test/tb_top.sv
